// ===== rtl/id_number_validate_decode_top_assert.svh =====
// Assertion macros for the citizen number validator checker.
`ifndef ID_NUMBER_VALIDATE_DECODE_TOP_ASSERT_SVH
`define ID_NUMBER_VALIDATE_DECODE_TOP_ASSERT_SVH

// Same-edge implication, disabled while in reset.
`define IDV_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("idv check failed");

// Implication over a fixed number of edges, disabled while in reset.
`define IDV_ASSERT_DELAY(lbl, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
    else $error("idv latency check failed");

`endif

// ===== rtl/idv_pkg.sv =====
// Shared types, constants and helper functions for the citizen number validator.
package idv_pkg;

  localparam int unsigned LATENCY = 12;

  localparam logic [43:0] ID_LIMIT     = 44'd10000000000000;
  localparam logic [23:0] E7           = 24'd10000000;
  localparam logic [27:0] RECIP_E7     = 28'd225179981;
  localparam logic [20:0] RECIP_E3     = 21'd1073742;
  localparam logic [24:0] RECIP_E4     = 25'd27487791;
  localparam logic [10:0] RECIP_10_N10 = 11'd1639;
  localparam logic [14:0] RECIP_100    = 15'd20972;
  localparam logic [7:0]  RECIP_10_N7  = 8'd205;
  localparam logic [9:0]  RECIP_11     = 10'd745;

  localparam logic [9:0]  PIVOT_RST    = 10'd26;
  localparam logic [11:0] MAX_YEAR_RST = 12'd2026;
  localparam logic [9:0]  FEMALE_MIN   = 10'd500;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_DIGITS = 2'd1,
    ST_DATE   = 2'd2,
    ST_CHECK  = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    CFG_PIVOT    = 1'b0,
    CFG_MAX_YEAR = 1'b1
  } cfg_reg_t;

  function automatic logic [4:0] month_len(input logic [6:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      7'd1:    len = 5'd31;
      7'd2:    len = leap ? 5'd29 : 5'd28;
      7'd3:    len = 5'd31;
      7'd4:    len = 5'd30;
      7'd5:    len = 5'd31;
      7'd6:    len = 5'd30;
      7'd7:    len = 5'd31;
      7'd8:    len = 5'd31;
      7'd9:    len = 5'd30;
      7'd10:   len = 5'd31;
      7'd11:   len = 5'd30;
      7'd12:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // Quotient by ten for values below 1000.
  function automatic logic [6:0] div10_n10(input logic [9:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'(RECIP_10_N10);
    return p[20:14];
  endfunction

  // Quotient by one hundred for values below 10000.
  function automatic logic [6:0] div100_n14(input logic [13:0] x);
    logic [28:0] p;
    p = 29'(x) * 29'(RECIP_100);
    return p[27:21];
  endfunction

  // Split a value below 100 into tens and units digits.
  function automatic logic [7:0] split_pair(input logic [6:0] x);
    logic [14:0] p;
    logic [3:0]  tens;
    logic [6:0]  rest;
    p    = 15'(x) * 15'(RECIP_10_N7);
    tens = p[14:11];
    rest = x - (7'(tens) * 7'd10);
    return {tens, rest[3:0]};
  endfunction

endpackage

// ===== rtl/id_number_validate_decode_top.sv =====
// Citizen number validator and decoder: top level.
// A word's result is on the out_ ports, with out_strobe high, once it has passed every pipeline register.
// Throughput: one word per cycle through a fixed twelve-stage pipeline; the reciprocal
// multiplier chain of the decimal split sets the depth. The receiver cannot stall.
// Reset (synchronous, active low) empties the pipeline and restores the pivot and year limit.
module id_number_validate_decode_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [43:0] in_id_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [11:0] cfg_data,
  output logic        out_strobe,
  output logic        out_valid_res,
  output logic [1:0]  out_status,
  output logic [6:0]  out_birth_day,
  output logic [6:0]  out_birth_month,
  output logic [11:0] out_birth_year,
  output logic [6:0]  out_region_code,
  output logic [9:0]  out_serial_code,
  output logic        out_is_female
);

  typedef struct packed {
    logic [43:0] w;
    logic        ov;
  } s2_t;

  typedef struct packed {
    logic [19:0] qe;
    logic [24:0] wl;
    logic        ov;
  } s3_t;

  typedef struct packed {
    logic [24:0] pm;
    logic [19:0] qe;
    logic [24:0] wl;
    logic        ov;
  } s4_t;

  typedef struct packed {
    logic [19:0] hi;
    logic [23:0] lo;
    logic        ov;
  } s5_t;

  typedef struct packed {
    logic [9:0]  ha;
    logic [9:0]  la;
    logic [19:0] hi;
    logic [23:0] lo;
    logic        ov;
  } s6_t;

  typedef struct packed {
    logic [9:0]  ga;
    logic [9:0]  gb;
    logic [9:0]  gc;
    logic [13:0] gd;
    logic        ov;
  } s7_t;

  typedef struct packed {
    logic [9:0]  ga;
    logic [9:0]  gb;
    logic [9:0]  gc;
    logic [13:0] gd;
    logic [6:0]  ta;
    logic [6:0]  tb;
    logic [6:0]  tc;
    logic [6:0]  th;
    logic        ov;
  } s8_t;

  typedef struct packed {
    logic [12:0][3:0] dg;
    logic             ov;
  } s9_t;

  typedef struct packed {
    logic [6:0]  day;
    logic [6:0]  month;
    logic [11:0] year;
    logic [6:0]  region;
    logic [9:0]  serial;
    logic [3:0]  chk_dg;
    logic        leap;
    logic [8:0]  sum;
    logic        ov;
  } s10_t;

  typedef struct packed {
    logic [6:0]  day;
    logic [6:0]  month;
    logic [11:0] year;
    logic [6:0]  region;
    logic [9:0]  serial;
    logic [3:0]  chk_dg;
    logic [8:0]  sum;
    logic [5:0]  q11;
    logic        date_ok;
    logic        ov;
  } s11_t;

  typedef struct packed {
    logic             valid_res;
    idv_pkg::status_t status;
    logic [6:0]       day;
    logic [6:0]       month;
    logic [11:0]      year;
    logic [6:0]       region;
    logic [9:0]       serial;
    logic             is_female;
  } res_t;

  logic                         accept;
  logic                         cfg_we;
  logic [9:0]                   pivot_r, pivot_nxt;
  logic [11:0]                  max_year_r, max_year_nxt;
  logic [idv_pkg::LATENCY-1:0]  vld_r, vld_nxt;

  logic [43:0] v1_r, v1_nxt;
  s2_t         s2_r, s2_nxt;
  s3_t         s3_r, s3_nxt;
  s4_t         s4_r, s4_nxt;
  s5_t         s5_r, s5_nxt;
  s6_t         s6_r, s6_nxt;
  s7_t         s7_r, s7_nxt;
  s8_t         s8_r, s8_nxt;
  s9_t         s9_r, s9_nxt;
  s10_t        s10_r, s10_nxt;
  s11_t        s11_r, s11_nxt;
  res_t        res_r, res_nxt;

  assign busy      = ~rst_n;
  assign cfg_ready = rst_n;
  assign accept    = start & ~busy;
  assign cfg_we    = cfg_valid & cfg_ready;

  always_comb begin
    pivot_nxt    = pivot_r;
    max_year_nxt = max_year_r;
    if (cfg_we) begin
      case (idv_pkg::cfg_reg_t'(cfg_index))
        idv_pkg::CFG_PIVOT:    pivot_nxt    = cfg_data[9:0];
        idv_pkg::CFG_MAX_YEAR: max_year_nxt = cfg_data;
        default: begin
          pivot_nxt    = pivot_r;
          max_year_nxt = max_year_r;
        end
      endcase
    end
  end

  assign vld_nxt = {vld_r[idv_pkg::LATENCY-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pivot_r    <= idv_pkg::PIVOT_RST;
      max_year_r <= idv_pkg::MAX_YEAR_RST;
      vld_r      <= '0;
    end else begin
      pivot_r    <= pivot_nxt;
      max_year_r <= max_year_nxt;
      vld_r      <= vld_nxt;
    end
  end

  assign v1_nxt = in_id_value;

  // Fold values of fourteen digits back into thirteen.
  always_comb begin
    s2_nxt.ov = (v1_r >= idv_pkg::ID_LIMIT);
    s2_nxt.w  = s2_nxt.ov ? (v1_r - idv_pkg::ID_LIMIT) : v1_r;
  end

  // Estimate the quotient by ten million, at most one short.
  always_comb begin
    logic [52:0] qprod;
    qprod     = 53'(s2_r.w[43:19]) * 53'(idv_pkg::RECIP_E7);
    s3_nxt.qe = qprod[51:32];
    s3_nxt.wl = s2_r.w[24:0];
    s3_nxt.ov = s2_r.ov;
  end

  always_comb begin
    logic [43:0] pprod;
    pprod     = 44'(s3_r.qe) * 44'(idv_pkg::E7);
    s4_nxt.pm = pprod[24:0];
    s4_nxt.qe = s3_r.qe;
    s4_nxt.wl = s3_r.wl;
    s4_nxt.ov = s3_r.ov;
  end

  always_comb begin
    logic [24:0] rem7;
    rem7 = s4_r.wl - s4_r.pm;
    if (rem7 >= 25'(idv_pkg::E7)) begin
      s5_nxt.hi = s4_r.qe + 20'd1;
      s5_nxt.lo = 24'(rem7 - 25'(idv_pkg::E7));
    end else begin
      s5_nxt.hi = s4_r.qe;
      s5_nxt.lo = rem7[23:0];
    end
    s5_nxt.ov = s4_r.ov;
  end

  always_comb begin
    logic [40:0] hprod;
    logic [48:0] lprod;
    hprod     = 41'(s5_r.hi) * 41'(idv_pkg::RECIP_E3);
    lprod     = 49'(s5_r.lo) * 49'(idv_pkg::RECIP_E4);
    s6_nxt.ha = hprod[39:30];
    s6_nxt.la = lprod[47:38];
    s6_nxt.hi = s5_r.hi;
    s6_nxt.lo = s5_r.lo;
    s6_nxt.ov = s5_r.ov;
  end

  always_comb begin
    s7_nxt.ga = s6_r.ha;
    s7_nxt.gb = 10'(s6_r.hi - (20'(s6_r.ha) * 20'd1000));
    s7_nxt.gc = s6_r.la;
    s7_nxt.gd = 14'(s6_r.lo - (24'(s6_r.la) * 24'd10000));
    s7_nxt.ov = s6_r.ov;
  end

  always_comb begin
    s8_nxt.ga = s7_r.ga;
    s8_nxt.gb = s7_r.gb;
    s8_nxt.gc = s7_r.gc;
    s8_nxt.gd = s7_r.gd;
    s8_nxt.ta = idv_pkg::div10_n10(s7_r.ga);
    s8_nxt.tb = idv_pkg::div10_n10(s7_r.gb);
    s8_nxt.tc = idv_pkg::div10_n10(s7_r.gc);
    s8_nxt.th = idv_pkg::div100_n14(s7_r.gd);
    s8_nxt.ov = s7_r.ov;
  end

  always_comb begin
    logic [6:0] gl;
    logic [7:0] pa, pb, pc, ph, pl;
    gl = 7'(s8_r.gd - (14'(s8_r.th) * 14'd100));
    pa = idv_pkg::split_pair(s8_r.ta);
    pb = idv_pkg::split_pair(s8_r.tb);
    pc = idv_pkg::split_pair(s8_r.tc);
    ph = idv_pkg::split_pair(s8_r.th);
    pl = idv_pkg::split_pair(gl);
    s9_nxt.dg[0]  = pa[7:4];
    s9_nxt.dg[1]  = pa[3:0];
    s9_nxt.dg[2]  = 4'(s8_r.ga - (10'(s8_r.ta) * 10'd10));
    s9_nxt.dg[3]  = pb[7:4];
    s9_nxt.dg[4]  = pb[3:0];
    s9_nxt.dg[5]  = 4'(s8_r.gb - (10'(s8_r.tb) * 10'd10));
    s9_nxt.dg[6]  = pc[7:4];
    s9_nxt.dg[7]  = pc[3:0];
    s9_nxt.dg[8]  = 4'(s8_r.gc - (10'(s8_r.tc) * 10'd10));
    s9_nxt.dg[9]  = ph[7:4];
    s9_nxt.dg[10] = ph[3:0];
    s9_nxt.dg[11] = pl[7:4];
    s9_nxt.dg[12] = pl[3:0];
    s9_nxt.ov     = s8_r.ov;
  end

  always_comb begin
    logic [12:0][3:0] d;
    logic [9:0]       y3;
    logic             mill;
    logic [4:0]       cent;
    logic             zero2;
    d              = s9_r.dg;
    y3             = (10'(d[4]) * 10'd100) + (10'(d[5]) * 10'd10) + 10'(d[6]);
    mill           = (y3 <= pivot_r);
    cent           = (mill ? 5'd20 : 5'd10) + 5'(d[4]);
    zero2          = (d[5] == 4'd0) && (d[6] == 4'd0);
    s10_nxt.day    = (7'(d[0]) * 7'd10) + 7'(d[1]);
    s10_nxt.month  = (7'(d[2]) * 7'd10) + 7'(d[3]);
    s10_nxt.year   = (mill ? 12'd2000 : 12'd1000) + 12'(y3);
    s10_nxt.region = (7'(d[7]) * 7'd10) + 7'(d[8]);
    s10_nxt.serial = (10'(d[9]) * 10'd100) + (10'(d[10]) * 10'd10) + 10'(d[11]);
    s10_nxt.chk_dg = d[12];
    s10_nxt.leap   = zero2 ? (cent[1:0] == 2'd0) : (s10_nxt.year[1:0] == 2'd0);
    s10_nxt.sum    = (9'd7 * (9'(d[0]) + 9'(d[6]))) + (9'd6 * (9'(d[1]) + 9'(d[7])))
                   + (9'd5 * (9'(d[2]) + 9'(d[8]))) + (9'd4 * (9'(d[3]) + 9'(d[9])))
                   + (9'd3 * (9'(d[4]) + 9'(d[10]))) + (9'd2 * (9'(d[5]) + 9'(d[11])));
    s10_nxt.ov     = s9_r.ov;
  end

  always_comb begin
    logic [18:0] mprod;
    logic [4:0]  mlen;
    mprod           = 19'(s10_r.sum) * 19'(idv_pkg::RECIP_11);
    mlen            = idv_pkg::month_len(s10_r.month, s10_r.leap);
    s11_nxt.day     = s10_r.day;
    s11_nxt.month   = s10_r.month;
    s11_nxt.year    = s10_r.year;
    s11_nxt.region  = s10_r.region;
    s11_nxt.serial  = s10_r.serial;
    s11_nxt.chk_dg  = s10_r.chk_dg;
    s11_nxt.sum     = s10_r.sum;
    s11_nxt.q11     = mprod[18:13];
    s11_nxt.date_ok = (s10_r.year != 12'd0) && (s10_r.year <= max_year_r)
                   && (s10_r.month >= 7'd1) && (s10_r.month <= 7'd12)
                   && (s10_r.day != 7'd0) && (s10_r.day <= 7'(mlen));
    s11_nxt.ov      = s10_r.ov;
  end

  always_comb begin
    logic [3:0] rem11;
    logic       chk_ok;
    rem11  = 4'(s11_r.sum - (9'(s11_r.q11) * 9'd11));
    chk_ok = (rem11 == 4'd0) ? (s11_r.chk_dg == 4'd0)
           : ((rem11 != 4'd1) && (s11_r.chk_dg == (4'd11 - rem11)));
    if (s11_r.ov) begin
      res_nxt.status = idv_pkg::ST_DIGITS;
    end else if (!s11_r.date_ok) begin
      res_nxt.status = idv_pkg::ST_DATE;
    end else if (!chk_ok) begin
      res_nxt.status = idv_pkg::ST_CHECK;
    end else begin
      res_nxt.status = idv_pkg::ST_OK;
    end
    res_nxt.valid_res = (res_nxt.status == idv_pkg::ST_OK);
    res_nxt.day       = s11_r.day;
    res_nxt.month     = s11_r.month;
    res_nxt.year      = s11_r.year;
    res_nxt.region    = s11_r.region;
    res_nxt.serial    = s11_r.serial;
    res_nxt.is_female = (s11_r.serial >= idv_pkg::FEMALE_MIN);
  end

  always_ff @(posedge clk) begin
    v1_r  <= v1_nxt;
    s2_r  <= s2_nxt;
    s3_r  <= s3_nxt;
    s4_r  <= s4_nxt;
    s5_r  <= s5_nxt;
    s6_r  <= s6_nxt;
    s7_r  <= s7_nxt;
    s8_r  <= s8_nxt;
    s9_r  <= s9_nxt;
    s10_r <= s10_nxt;
    s11_r <= s11_nxt;
    res_r <= res_nxt;
  end

  assign out_strobe      = vld_r[idv_pkg::LATENCY-1];
  assign out_valid_res   = res_r.valid_res;
  assign out_status      = res_r.status;
  assign out_birth_day   = res_r.day;
  assign out_birth_month = res_r.month;
  assign out_birth_year  = res_r.year;
  assign out_region_code = res_r.region;
  assign out_serial_code = res_r.serial;
  assign out_is_female   = res_r.is_female;

endmodule

// ===== rtl/idv_checker.sv =====
// Port-level assertion checker for the citizen number validator, bound to the top level.
`include "id_number_validate_decode_top_assert.svh"

module idv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [43:0] in_id_value,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [0:0]  cfg_index,
  input logic [11:0] cfg_data,
  input logic        out_strobe,
  input logic        out_valid_res,
  input logic [1:0]  out_status,
  input logic [6:0]  out_birth_day,
  input logic [6:0]  out_birth_month,
  input logic [11:0] out_birth_year,
  input logic [6:0]  out_region_code,
  input logic [9:0]  out_serial_code,
  input logic        out_is_female
);

  `IDV_ASSERT(a_valid_matches_status, out_strobe, out_valid_res == (out_status == idv_pkg::ST_OK))
  `IDV_ASSERT(a_female_from_serial, out_strobe, out_is_female == (out_serial_code >= idv_pkg::FEMALE_MIN))
  `IDV_ASSERT(a_ok_date_fields, out_strobe && out_status == idv_pkg::ST_OK, out_birth_month >= 7'd1 && out_birth_month <= 7'd12 && out_birth_day != 7'd0)
  `IDV_ASSERT_DELAY(a_word_delivered, start && !busy, idv_pkg::LATENCY, out_strobe)
  `IDV_ASSERT(a_no_invented_word, out_strobe, $past(start && !busy, idv_pkg::LATENCY))

endmodule

bind id_number_validate_decode_top idv_checker u_idv_checker (.*);

// ===== test/tb.sv =====
// Testbench for the citizen number validator: directed, random and register sweep traffic.
module tb;

  typedef struct {
    logic              valid_res;
    idv_pkg::status_t  status;
    logic [6:0]        day;
    logic [6:0]        month;
    logic [11:0]       year;
    logic [6:0]        region;
    logic [9:0]        serial;
    logic              female;
  } id_record_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [43:0] in_id_value;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [11:0] cfg_data;
  logic        out_strobe;
  logic        out_valid_res;
  logic [1:0]  out_status;
  logic [6:0]  out_birth_day;
  logic [6:0]  out_birth_month;
  logic [11:0] out_birth_year;
  logic [6:0]  out_region_code;
  logic [9:0]  out_serial_code;
  logic        out_is_female;

  logic [9:0]  pivot_q;
  logic [11:0] max_year_q;
  id_record_t  expected_ids[$];
  int unsigned mismatch_count;
  int unsigned gap_max;

  id_number_validate_decode_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_id_value     (in_id_value),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_strobe      (out_strobe),
    .out_valid_res   (out_valid_res),
    .out_status      (out_status),
    .out_birth_day   (out_birth_day),
    .out_birth_month (out_birth_month),
    .out_birth_year  (out_birth_year),
    .out_region_code (out_region_code),
    .out_serial_code (out_serial_code),
    .out_is_female   (out_is_female)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void split_digits(input logic [43:0] v, output int unsigned dg[13]);
    logic [63:0] t;
    t = 64'(v);
    for (int i = 12; i >= 0; i--) begin
      dg[i] = int'(t % 10);
      t = t / 10;
    end
  endfunction

  function automatic int unsigned weighted_check(input logic [43:0] v);
    int unsigned dg[13];
    int unsigned sum;
    split_digits(v, dg);
    sum = 0;
    for (int i = 0; i < 6; i++) sum += (7 - i) * (dg[i] + dg[i + 6]);
    return (sum % 11 == 0) ? 0 : 11 - sum % 11;
  endfunction

  function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
    logic leap;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    case (m)
      2: return leap ? 29 : 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  function automatic int unsigned full_year(input int unsigned y3);
    return (y3 <= pivot_q) ? 2000 + y3 : 1000 + y3;
  endfunction

  function automatic id_record_t decode_id(input logic [43:0] v);
    int unsigned dg[13];
    int unsigned day, month, year, serial, chk;
    logic        date_good;
    id_record_t  r;
    split_digits(v, dg);
    day    = 10 * dg[0] + dg[1];
    month  = 10 * dg[2] + dg[3];
    year   = full_year(100 * dg[4] + 10 * dg[5] + dg[6]);
    serial = 100 * dg[9] + 10 * dg[10] + dg[11];
    chk    = weighted_check(v);
    date_good = (year >= 1) && (year <= max_year_q) && (month >= 1) && (month <= 12)
                && (day >= 1);
    if (date_good) date_good = (day <= month_length(month, year));
    if (v >= idv_pkg::ID_LIMIT) r.status = idv_pkg::ST_DIGITS;
    else if (!date_good) r.status = idv_pkg::ST_DATE;
    else if (chk == 10 || chk != dg[12]) r.status = idv_pkg::ST_CHECK;
    else r.status = idv_pkg::ST_OK;
    r.valid_res = (r.status == idv_pkg::ST_OK);
    r.day       = 7'(day);
    r.month     = 7'(month);
    r.year      = 12'(year);
    r.region    = 7'(10 * dg[7] + dg[8]);
    r.serial    = 10'(serial);
    r.female    = (serial >= 500);
    return r;
  endfunction

  function automatic logic [43:0] body_id(input int unsigned day, input int unsigned month,
                                          input int unsigned y3, input int unsigned region,
                                          input int unsigned serial);
    logic [63:0] n;
    n = 64'(day);
    n = n * 100 + month;
    n = n * 1000 + y3;
    n = n * 100 + region;
    n = n * 1000 + serial;
    return 44'(n * 10);
  endfunction

  function automatic logic [43:0] seal_id(input logic [43:0] v);
    int unsigned chk;
    chk = weighted_check(v);
    return v + 44'((chk == 10) ? 0 : chk);
  endfunction

  function automatic logic [43:0] spoil_check(input logic [43:0] v);
    return v - (v % 10) + ((v % 10) + 1) % 10;
  endfunction

  function automatic logic [43:0] random_id();
    int unsigned kind, day, month, y3, len;
    logic [43:0] v;
    kind  = $urandom_range(0, 99);
    y3    = $urandom_range(0, 999);
    month = $urandom_range(1, 12);
    len   = month_length(month, full_year(y3));
    day   = $urandom_range(1, len);
    if (kind >= 60 && kind < 70) begin
      case ($urandom_range(0, 3))
        0: day = 0;
        1: day = $urandom_range(len + 1, 99);
        2: month = 0;
        default: month = $urandom_range(13, 99);
      endcase
    end
    v = seal_id(body_id(day, month, y3, $urandom_range(0, 99), $urandom_range(0, 999)));
    if (kind >= 70 && kind < 80) begin
      v = spoil_check(v);
    end else if (kind >= 80 && kind < 90) begin
      v = 44'({$urandom, $urandom} % idv_pkg::ID_LIMIT);
    end else if (kind >= 90) begin
      v = 44'({$urandom, $urandom});
      if (v < idv_pkg::ID_LIMIT) v = v + idv_pkg::ID_LIMIT;
    end
    return v;
  endfunction

  task automatic note_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      if (mismatch_count < 10)
        $display("%0t %s: expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : watch_results
    id_record_t want;
    if (rst_n) begin
      if (out_strobe) begin
        if (expected_ids.size() == 0) begin
          if (mismatch_count < 10) $display("%0t result word with none expected", $time);
          mismatch_count++;
        end else begin
          want = expected_ids.pop_front();
          note_field("valid_res", want.valid_res, out_valid_res);
          note_field("status", want.status, out_status);
          note_field("birth_day", want.day, out_birth_day);
          note_field("birth_month", want.month, out_birth_month);
          note_field("birth_year", want.year, out_birth_year);
          note_field("region_code", want.region, out_region_code);
          note_field("serial_code", want.serial, out_serial_code);
          note_field("is_female", want.female, out_is_female);
        end
      end
      if (start && !busy) expected_ids.push_back(decode_id(in_id_value));
    end
  end

  task automatic send_id(input logic [43:0] v);
    int unsigned gap;
    gap = $urandom_range(0, gap_max);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_id_value <= v;
    do @(posedge clk); while (busy);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (expected_ids.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input idv_pkg::cfg_reg_t idx, input logic [11:0] data);
    int unsigned gap;
    gap = $urandom_range(0, 19);
    if (gap != 0) begin
      cfg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == idv_pkg::CFG_PIVOT) pivot_q = data[9:0];
    else max_year_q = data;
  endtask

  task automatic test_directed_cases();
    logic [43:0] v;
    gap_max = 3;
    send_id(44'd0);
    send_id(idv_pkg::ID_LIMIT - 44'd1);
    send_id(idv_pkg::ID_LIMIT);
    send_id({44{1'b1}});
    send_id(seal_id(body_id(1, 1, 0, 0, 0)));
    send_id(seal_id(body_id(29, 2, 0, 12, 345)));
    send_id(seal_id(body_id(29, 2, 600, 40, 1)));
    send_id(seal_id(body_id(29, 2, 900, 40, 2)));
    send_id(seal_id(body_id(29, 2, 4, 71, 3)));
    send_id(seal_id(body_id(29, 2, 3, 71, 4)));
    send_id(seal_id(body_id(31, 4, 990, 8, 5)));
    send_id(seal_id(body_id(30, 4, 990, 8, 6)));
    send_id(seal_id(body_id(31, 12, 26, 99, 999)));
    send_id(seal_id(body_id(31, 12, 27, 0, 0)));
    send_id(seal_id(body_id(15, 6, 985, 50, 499)));
    send_id(seal_id(body_id(15, 6, 985, 50, 500)));
    send_id(seal_id(body_id(10, 0, 950, 1, 7)));
    send_id(seal_id(body_id(10, 13, 950, 1, 8)));
    send_id(seal_id(body_id(32, 1, 950, 1, 9)));
    send_id(spoil_check(seal_id(body_id(7, 7, 977, 7, 123))));
    // hunt for a number whose check value is ten
    do begin
      v = body_id($urandom_range(1, 28), $urandom_range(1, 12), $urandom_range(27, 999),
                  $urandom_range(0, 99), $urandom_range(0, 999));
    end while (weighted_check(v) != 10);
    send_id(v + 44'($urandom_range(0, 9)));
    send_id(idv_pkg::ID_LIMIT + seal_id(body_id(12, 5, 980, 17, 600)));
  endtask

  task automatic test_random_traffic();
    for (int n = 0; n < 700; n++) begin
      if (n % 50 == 0) gap_max = $urandom_range(0, 1) ? 19 : 0;
      send_id(random_id());
    end
  endtask

  task automatic test_register_settings();
    logic [11:0] p, y;
    int unsigned y3;
    for (int s = 0; s < 9; s++) begin
      case (s)
        0: begin p = 12'd0;   y = 12'd1;    end
        1: begin p = 12'hFFF; y = 12'd0;    end
        2: begin p = 12'd999; y = 12'd2999; end
        3: begin p = 12'd500; y = 12'd1999; end
        4: begin p = 12'h3FF; y = 12'hFFF;  end
        5: begin p = 12'd26;  y = 12'd2026; end
        default: begin p = 12'($urandom); y = 12'($urandom); end
      endcase
      settle();
      write_reg(idv_pkg::CFG_PIVOT, p);
      write_reg(idv_pkg::CFG_MAX_YEAR, y);
      cfg_valid <= 1'b0;
      gap_max = $urandom_range(0, 1) ? 19 : 0;
      // probe the latest accepted year and the one after it
      for (int unsigned d = 0; d < 2; d++) begin
        y3 = (max_year_q + d) % 1000;
        if (full_year(y3) == max_year_q + d) send_id(seal_id(body_id(28, 2, y3, 0, 0)));
      end
      for (int n = 0; n < 40; n++) send_id(random_id());
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_id_value <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= idv_pkg::CFG_PIVOT;
    cfg_data    <= '0;
    pivot_q        = idv_pkg::PIVOT_RST;
    max_year_q     = idv_pkg::MAX_YEAR_RST;
    mismatch_count = 0;
    gap_max        = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_random_traffic();
    test_register_settings();
    settle();
    repeat (idv_pkg::LATENCY + 4) @(posedge clk);
    if (mismatch_count == 0 && expected_ids.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
